// File: src/wtm_pkg.sv
// wtm_pkg: shared constants, types and helpers of the wavetable tone mixer
// used by wtm_lane, wtm_mixer, wavetable_tone_mixer_unit and wtm_checker
// no dependencies
`default_nettype none

package wtm_pkg;

  // default sizes handed to the top level parameters
  localparam int TABLE_DEPTH_DEF  = 16384;
  localparam int NUM_WAVES_DEF    = 4;
  localparam int NUM_CHANNELS_DEF = 4;

  // channels that carry an enable bit, a frequency and a wave selector
  localparam int FIELD_CHANNELS = 4;

  // field widths
  localparam int SAMPLE_W  = 16;
  localparam int FREQ_W    = 14;
  localparam int ADDR_W    = 14;
  localparam int OP_W      = 2;
  localparam int WID_W     = 2;
  localparam int EN_W      = 4;
  localparam int TLEN_W    = 15;
  localparam int GAIN_W    = 15;
  localparam int WSEL_W    = 8;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 15;

  // input tdata layout, lowest bit first
  localparam int WID_LSB  = 0;
  localparam int ADDR_LSB = WID_LSB + WID_W;
  localparam int VAL_LSB  = ADDR_LSB + ADDR_W;
  localparam int EN_LSB   = VAL_LSB + SAMPLE_W;
  localparam int FREQ_LSB = EN_LSB + EN_W;
  localparam int IN_BITS  = FREQ_LSB + FIELD_CHANNELS * FREQ_W;
  localparam int S_TDATA_W = ((IN_BITS + 7) / 8) * 8;
  localparam int M_TDATA_W = SAMPLE_W;

  // gain scaling by 1/10000 through a reciprocal multiply
  localparam int GAIN_UNIT   = 10000;
  localparam int RECIP_SHIFT = 30;
  localparam int GAIN_RECIP  = (1 << RECIP_SHIFT) / GAIN_UNIT;
  localparam int RECIP_W     = 17;
  localparam int MAG_W       = 30;
  localparam int MAG_HALF    = MAG_W / 2;
  localparam int PP_W        = 32;
  localparam int QUOT_W      = 17;
  localparam int QREM_W      = 15;

  // eight-bit output conversion s/256+128
  localparam int BYTE_SHIFT = 8;
  localparam int BYTE_ROUND = (1 << BYTE_SHIFT) - 1;
  localparam int BYTE_BIAS  = 128;

  // register reset values
  localparam logic [TLEN_W-1:0] TLEN_RST = TLEN_W'(8000);
  localparam logic [GAIN_W-1:0] GAIN_RST = GAIN_W'(10000);

  typedef enum logic [OP_W-1:0] {
    OP_LOAD  = 2'd0,
    OP_GEN   = 2'd1,
    OP_CLEAR = 2'd2
  } op_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TLEN = 2'd0,
    REG_GAIN = 2'd1,
    REG_WSEL = 2'd2,
    REG_EBIT = 2'd3
  } cfg_reg_e;

  // per-transaction control from the top level to every lane
  typedef struct packed {
    logic start;
    logic clear;
    logic commit;
  } lane_ctrl_t;

  // wave selector reduced modulo the number of tables (selector is below 4)
  function automatic logic [1:0] wave_mod(logic [1:0] sel, int unsigned n);
    logic [4:0] r;
    r = {3'b000, sel};
    for (int i = 0; i < 4; i++) begin
      if (r >= 5'(n)) r = r - 5'(n);
    end
    return r[1:0];
  endfunction

endpackage

`default_nettype wire

// File: src/wavetable_tone_mixer_unit.sv
// wavetable_tone_mixer_unit: top level of the multichannel wavetable mixer
// instantiates wtm_lane (one per channel, at most FIELD_CHANNELS) and wtm_mixer; uses wtm_pkg
//
// Usage:
//   s_axis carries commands, tuser gives the op (load, generate, clear).
//   A load writes one table word, a clear zeroes every channel phase; both
//   give no output. A generate gives one mixed sample on m_axis. The cfg
//   channel writes table length, gain, wave select and the eight-bit mode;
//   it is always ready; the user must use it only while idle, as the block
//   itself does not enforce this. The lane dividers produce one remainder
//   bit per cycle; the phases and the sample are committed once the dividers
//   and the merge stage are done and the output register is free. The merge
//   stage reads the enabled channels one per pass through the single table
//   read port. One generate is in flight at a time; the command stream is
//   not ready until it is committed. The result sits in an output
//   register, and loads and clears are taken while it waits; a following
//   generate finishes its work and holds until m_axis_tready frees the
//   register. Reset zeroes all phases and restores the register defaults;
//   table contents are undefined until loaded.
`default_nettype none

module wavetable_tone_mixer_unit #(
  parameter int TABLE_DEPTH  = wtm_pkg::TABLE_DEPTH_DEF,
  parameter int NUM_WAVES    = wtm_pkg::NUM_WAVES_DEF,
  parameter int NUM_CHANNELS = wtm_pkg::NUM_CHANNELS_DEF
) (
  input  wire                               clk_i,
  input  wire                               rst_ni,
  // command stream
  input  wire                               s_axis_tvalid,
  output logic                              s_axis_tready,
  // wave_id, table_addr, table_value, channel_enable, freq_a..freq_d
  input  wire  [wtm_pkg::S_TDATA_W-1:0]     s_axis_tdata,
  // op
  input  wire  [wtm_pkg::OP_W-1:0]          s_axis_tuser,
  // sample stream
  output logic                              m_axis_tvalid,
  input  wire                               m_axis_tready,
  // sample_out
  output logic [wtm_pkg::M_TDATA_W-1:0]     m_axis_tdata,
  // register writes
  input  wire                               cfg_valid_i,
  output logic                              cfg_ready_o,
  input  wire  [wtm_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  wire  [wtm_pkg::CFG_DAT_W-1:0]     cfg_data_i
);

  localparam int NL = (NUM_CHANNELS < wtm_pkg::FIELD_CHANNELS) ? NUM_CHANNELS
                                                              : wtm_pkg::FIELD_CHANNELS;
  localparam int PW = $clog2(TABLE_DEPTH);
  localparam int LW = $clog2(TABLE_DEPTH + 1);
  localparam int AW = $clog2(NUM_WAVES * TABLE_DEPTH);
  localparam logic [wtm_pkg::EN_W-1:0] EN_MASK = wtm_pkg::EN_W'((1 << NL) - 1);
  localparam int SW16 = wtm_pkg::SAMPLE_W;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_RUN  = 2'b10
  } state_e;

  state_e state_q;

  logic [wtm_pkg::TLEN_W-1:0] tlen_q;
  logic [wtm_pkg::GAIN_W-1:0] gain_q;
  logic [wtm_pkg::WSEL_W-1:0] wsel_q;
  logic                       ebit_q;

  logic                       out_vld_q;
  logic [SW16-1:0]            out_q;
  logic [SW16-1:0]            out_d;

  logic                       in_acc;
  logic                       gen_acc;
  logic                       load_ok;
  logic                       out_free;
  logic                       run_done;
  logic                       mix_busy;
  logic [SW16-1:0]            mix_sum;
  logic [LW-1:0]              len_eff;
  logic [AW-1:0]              wr_addr;
  logic [NL-1:0]              lane_busy;
  logic [wtm_pkg::FIELD_CHANNELS-1:0][PW-1:0] lane_phase;
  logic signed [SW16:0]       byte_t;
  logic signed [SW16:0]       byte_d;

  wtm_pkg::lane_ctrl_t        lane_ctrl;

  logic [wtm_pkg::WID_W-1:0]  in_wid;
  logic [wtm_pkg::ADDR_W-1:0] in_addr;
  logic [SW16-1:0]            in_val;
  logic [wtm_pkg::EN_W-1:0]   in_en;

  assign in_wid  = s_axis_tdata[wtm_pkg::WID_LSB  +: wtm_pkg::WID_W];
  assign in_addr = s_axis_tdata[wtm_pkg::ADDR_LSB +: wtm_pkg::ADDR_W];
  assign in_val  = s_axis_tdata[wtm_pkg::VAL_LSB  +: SW16];
  assign in_en   = s_axis_tdata[wtm_pkg::EN_LSB   +: wtm_pkg::EN_W];

  // handshake decode
  assign s_axis_tready = (state_q == ST_IDLE);
  assign cfg_ready_o   = 1'b1;
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign gen_acc       = in_acc && (s_axis_tuser == wtm_pkg::OP_GEN);
  assign out_free      = !out_vld_q || m_axis_tready;
  assign run_done      = (state_q == ST_RUN) && !mix_busy && !(|lane_busy) && out_free;

  // lane control for this transaction
  always_comb begin
    lane_ctrl.start  = gen_acc;
    lane_ctrl.clear  = in_acc && (s_axis_tuser == wtm_pkg::OP_CLEAR);
    lane_ctrl.commit = run_done;
  end

  // table load address, out-of-range loads dropped
  always_comb begin
    load_ok = in_acc && (s_axis_tuser == wtm_pkg::OP_LOAD)
              && ({3'b000, in_wid} < 5'(NUM_WAVES))
              && (17'(in_addr) < 17'(TABLE_DEPTH));
    wr_addr = AW'(in_wid) * AW'(TABLE_DEPTH) + AW'(in_addr);
  end

  // effective table length, clamped to 1..TABLE_DEPTH
  always_comb begin
    if (tlen_q == '0) begin
      len_eff = LW'(1);
    end else if (32'(tlen_q) > 32'(TABLE_DEPTH)) begin
      len_eff = LW'(TABLE_DEPTH);
    end else begin
      len_eff = LW'(tlen_q);
    end
  end

  // channel lanes
  for (genvar c = 0; c < wtm_pkg::FIELD_CHANNELS; c++) begin : g_lane
    if (c < NL) begin : g_used
      wtm_lane #(
        .PW (PW),
        .LW (LW)
      ) u_lane (
        .clk_i   (clk_i),
        .rst_ni  (rst_ni),
        .ctrl_i  (lane_ctrl),
        .en_i    (in_en[c]),
        .freq_i  (s_axis_tdata[wtm_pkg::FREQ_LSB + c * wtm_pkg::FREQ_W +: wtm_pkg::FREQ_W]),
        .len_i   (len_eff),
        .phase_o (lane_phase[c]),
        .busy_o  (lane_busy[c])
      );
    end else begin : g_absent
      assign lane_phase[c] = '0;
    end
  end

  // merge stage with the table memory
  wtm_mixer #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .NUM_WAVES   (NUM_WAVES),
    .PW          (PW),
    .AW          (AW)
  ) u_mixer (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (gen_acc),
    .en_i      (in_en & EN_MASK),
    .phase_i   (lane_phase),
    .wsel_i    (wsel_q),
    .gain_i    (gain_q),
    .wr_en_i   (load_ok),
    .wr_addr_i (wr_addr),
    .wr_data_i (in_val),
    .busy_o    (mix_busy),
    .sum_o     (mix_sum)
  );

  // optional eight-bit conversion, s/256 toward zero plus bias
  always_comb begin
    byte_t = $signed({mix_sum[SW16-1], mix_sum})
             + (mix_sum[SW16-1] ? (SW16+1)'(wtm_pkg::BYTE_ROUND) : '0);
    byte_d = (byte_t >>> wtm_pkg::BYTE_SHIFT)
             + $signed((SW16+1)'(wtm_pkg::BYTE_BIAS));
    out_d  = ebit_q ? byte_d[SW16-1:0] : mix_sum;
  end

  // control state, registers and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      out_vld_q <= 1'b0;
      tlen_q    <= wtm_pkg::TLEN_RST;
      gain_q    <= wtm_pkg::GAIN_RST;
      wsel_q    <= '0;
      ebit_q    <= 1'b0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        case (wtm_pkg::cfg_reg_e'(cfg_index_i))
          wtm_pkg::REG_TLEN: tlen_q <= cfg_data_i[wtm_pkg::TLEN_W-1:0];
          wtm_pkg::REG_GAIN: gain_q <= cfg_data_i[wtm_pkg::GAIN_W-1:0];
          wtm_pkg::REG_WSEL: wsel_q <= cfg_data_i[wtm_pkg::WSEL_W-1:0];
          wtm_pkg::REG_EBIT: ebit_q <= cfg_data_i[0];
          default: ;
        endcase
      end
      case (state_q)
        ST_IDLE: if (gen_acc) state_q <= ST_RUN;
        ST_RUN:  if (run_done) state_q <= ST_IDLE;
        default: state_q <= ST_IDLE;
      endcase
      if (run_done) begin
        out_vld_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // output payload register
  always_ff @(posedge clk_i) begin
    if (run_done) out_q <= out_d;
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_q;

endmodule

`default_nettype wire

// File: src/wtm_lane.sv
// wtm_lane: one channel lane, holds the channel phase and steps it by its
// frequency modulo the table length with a bit-serial restoring divider
// depends on wtm_pkg
`default_nettype none

module wtm_lane #(
  parameter int PW = 14,
  parameter int LW = 15
) (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire wtm_pkg::lane_ctrl_t     ctrl_i,
  input  wire                          en_i,
  input  wire  [wtm_pkg::FREQ_W-1:0]   freq_i,
  input  wire  [LW-1:0]                len_i,
  output logic [PW-1:0]                phase_o,
  output logic                         busy_o
);

  localparam int SW = ((PW > wtm_pkg::FREQ_W) ? PW : wtm_pkg::FREQ_W) + 1;
  localparam int CW = $clog2(SW + 1);

  logic [PW-1:0] phase_q;
  logic          busy_q;
  logic          en_q;
  logic [CW-1:0] cnt_q;
  logic [SW-1:0] dvd_q;
  logic [LW-1:0] rem_q;
  logic [LW-1:0] rem_d;
  logic [LW:0]   shifted;

  // one restoring step: bring in the next dividend bit, subtract if it fits
  always_comb begin
    shifted = {rem_q, dvd_q[SW-1]};
    if (shifted >= {1'b0, len_i}) begin
      rem_d = LW'(shifted - {1'b0, len_i});
    end else begin
      rem_d = LW'(shifted);
    end
  end

  // phase and divider control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= '0;
      busy_q  <= 1'b0;
      en_q    <= 1'b0;
      cnt_q   <= '0;
    end else begin
      if (ctrl_i.clear) begin
        phase_q <= '0;
      end else if (ctrl_i.commit && en_q) begin
        phase_q <= PW'(rem_q);
      end
      if (ctrl_i.start) begin
        busy_q <= 1'b1;
        en_q   <= en_i;
        cnt_q  <= CW'(SW);
      end else if (busy_q) begin
        cnt_q <= cnt_q - CW'(1);
        if (cnt_q == CW'(1)) busy_q <= 1'b0;
      end
    end
  end

  // dividend shift line and partial remainder
  always_ff @(posedge clk_i) begin
    if (ctrl_i.start) begin
      dvd_q <= SW'(phase_q) + SW'(freq_i);
      rem_q <= '0;
    end else if (busy_q) begin
      dvd_q <= dvd_q << 1;
      rem_q <= rem_d;
    end
  end

  assign phase_o = phase_q;
  assign busy_o  = busy_q;

endmodule

`default_nettype wire

// File: src/wtm_mixer.sv
// wtm_mixer: wave table memory and merge stage, reads each enabled channel
// in order, scales the first by gain/10000 and averages the rest into it
// depends on wtm_pkg
`default_nettype none

module wtm_mixer #(
  parameter int TABLE_DEPTH = wtm_pkg::TABLE_DEPTH_DEF,
  parameter int NUM_WAVES   = wtm_pkg::NUM_WAVES_DEF,
  parameter int PW          = 14,
  parameter int AW          = 16
) (
  input  wire                                              clk_i,
  input  wire                                              rst_ni,
  input  wire                                              start_i,
  input  wire  [wtm_pkg::EN_W-1:0]                         en_i,
  input  wire  [wtm_pkg::FIELD_CHANNELS-1:0][PW-1:0]       phase_i,
  input  wire  [wtm_pkg::WSEL_W-1:0]                       wsel_i,
  input  wire  [wtm_pkg::GAIN_W-1:0]                       gain_i,
  input  wire                                              wr_en_i,
  input  wire  [AW-1:0]                                    wr_addr_i,
  input  wire  [wtm_pkg::SAMPLE_W-1:0]                     wr_data_i,
  output logic                                             busy_o,
  output logic [wtm_pkg::SAMPLE_W-1:0]                     sum_o
);

  localparam int MEM_DEPTH = NUM_WAVES * TABLE_DEPTH;
  localparam int SW16 = wtm_pkg::SAMPLE_W;
  localparam int MW   = wtm_pkg::MAG_W;
  localparam int MH   = wtm_pkg::MAG_HALF;
  localparam int QW   = wtm_pkg::QUOT_W;
  localparam logic [wtm_pkg::RECIP_W-1:0] RECIP = wtm_pkg::RECIP_W'(wtm_pkg::GAIN_RECIP);
  localparam logic [13:0] UNIT = 14'(wtm_pkg::GAIN_UNIT);

  typedef enum logic [7:0] {
    M_IDLE = 8'b0000_0001,
    M_SCAN = 8'b0000_0010,
    M_DATA = 8'b0000_0100,
    M_G1   = 8'b0000_1000,
    M_G2   = 8'b0001_0000,
    M_G3   = 8'b0010_0000,
    M_G4   = 8'b0100_0000,
    M_G5   = 8'b1000_0000
  } mix_state_e;

  mix_state_e state_q;
  logic [2:0] ch_q;
  logic       started_q;
  logic [wtm_pkg::EN_W-1:0] en_q;

  logic [SW16-1:0] mem_q [MEM_DEPTH];
  logic [SW16-1:0] rd_data_q;
  logic [AW-1:0]   rd_addr;
  logic [1:0]      wave;
  logic [1:0]      ch_idx;

  logic signed [SW16-1:0]  sum_q;
  logic signed [31:0]      prod_q;
  logic                    neg_q;
  logic [MW-1:0]           mag_q;
  logic [wtm_pkg::PP_W-1:0] pp_hi_q;
  logic [wtm_pkg::PP_W-1:0] pp_lo_q;
  logic [QW-1:0]           q0_q;
  logic [wtm_pkg::QREM_W-1:0] qrem_q;

  logic signed [SW16:0]    avg_t;
  logic signed [SW16:0]    avg_d;
  logic [MH+wtm_pkg::PP_W-1:0] pp_sum;
  logic [QW-1:0]           quot;
  logic [QW-1:0]           quot_s;
  logic [30:0]             q0_scaled;
  logic signed [31:0]      prod_neg;

  assign ch_idx = ch_q[1:0];

  // read address of the channel under scan: selected table, then phase
  always_comb begin
    wave    = wtm_pkg::wave_mod(wsel_i[{ch_idx, 1'b0} +: 2], NUM_WAVES);
    rd_addr = AW'(wave) * AW'(TABLE_DEPTH) + AW'(phase_i[ch_idx]);
  end

  // table memory, one write and one registered read port
  always_ff @(posedge clk_i) begin
    if (wr_en_i) mem_q[wr_addr_i] <= wr_data_i;
    rd_data_q <= mem_q[rd_addr];
  end

  // running average truncated toward zero
  always_comb begin
    avg_t = $signed({sum_q[SW16-1], sum_q}) + $signed({rd_data_q[SW16-1], rd_data_q});
    avg_d = (avg_t + $signed({{SW16{1'b0}}, avg_t[SW16]})) >>> 1;
  end

  // gain pipeline arithmetic
  always_comb begin
    prod_neg  = -prod_q;
    pp_sum    = {pp_hi_q, {MH{1'b0}}} + (MH + wtm_pkg::PP_W)'(pp_lo_q);
    q0_scaled = 31'(q0_q) * 31'(UNIT);
    quot      = q0_q + QW'(qrem_q >= wtm_pkg::QREM_W'(wtm_pkg::GAIN_UNIT));
    quot_s    = neg_q ? (QW'(0) - quot) : quot;
  end

  // scan sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= M_IDLE;
      ch_q      <= '0;
      started_q <= 1'b0;
      en_q      <= '0;
    end else begin
      case (state_q)
        M_IDLE: begin
          if (start_i) begin
            state_q   <= M_SCAN;
            ch_q      <= '0;
            started_q <= 1'b0;
            en_q      <= en_i;
          end
        end
        M_SCAN: begin
          if (ch_q == 3'(wtm_pkg::FIELD_CHANNELS)) begin
            state_q <= M_IDLE;
          end else if (en_q[ch_idx]) begin
            state_q <= M_DATA;
          end else begin
            ch_q <= ch_q + 3'd1;
          end
        end
        M_DATA: begin
          if (started_q) begin
            ch_q    <= ch_q + 3'd1;
            state_q <= M_SCAN;
          end else begin
            state_q <= M_G1;
          end
        end
        M_G1: state_q <= M_G2;
        M_G2: state_q <= M_G3;
        M_G3: state_q <= M_G4;
        M_G4: state_q <= M_G5;
        M_G5: begin
          started_q <= 1'b1;
          ch_q      <= ch_q + 3'd1;
          state_q   <= M_SCAN;
        end
        default: state_q <= M_IDLE;
      endcase
    end
  end

  // datapath registers of the merge stage
  always_ff @(posedge clk_i) begin
    case (state_q)
      M_IDLE: begin
        if (start_i) sum_q <= '0;
      end
      M_DATA: begin
        if (started_q) begin
          sum_q <= avg_d[SW16-1:0];
        end else begin
          prod_q <= $signed(rd_data_q) * $signed({1'b0, gain_i});
        end
      end
      M_G1: begin
        neg_q <= prod_q[31];
        mag_q <= prod_q[31] ? MW'(prod_neg) : MW'(prod_q);
      end
      M_G2: begin
        pp_hi_q <= wtm_pkg::PP_W'(mag_q[MW-1:MH]) * wtm_pkg::PP_W'(RECIP);
        pp_lo_q <= wtm_pkg::PP_W'(mag_q[MH-1:0]) * wtm_pkg::PP_W'(RECIP);
      end
      M_G3: q0_q <= pp_sum[wtm_pkg::RECIP_SHIFT +: QW];
      M_G4: qrem_q <= wtm_pkg::QREM_W'(31'(mag_q) - q0_scaled);
      M_G5: sum_q <= quot_s[SW16-1:0];
      default: ;
    endcase
  end

  assign busy_o = (state_q != M_IDLE);
  assign sum_o  = sum_q;

endmodule

`default_nettype wire

// File: src/wtm_checker.sv
// wtm_checker: port-level checks on the wavetable tone mixer, bound to the top
// depends on wtm_pkg and wavetable_tone_mixer_unit
`default_nettype none

module wtm_checker (
  input wire                               clk_i,
  input wire                               rst_ni,
  input wire                               s_axis_tvalid,
  input wire                               s_axis_tready,
  input wire [wtm_pkg::OP_W-1:0]           s_axis_tuser,
  input wire                               m_axis_tvalid,
  input wire                               m_axis_tready,
  input wire [wtm_pkg::M_TDATA_W-1:0]      m_axis_tdata
);

  // a stalled sample stays offered
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("sample dropped while stalled");

  // a stalled sample keeps its value
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
    else $error("sample changed while stalled");

  // a generate transaction closes the command channel while it runs
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && (s_axis_tuser == wtm_pkg::OP_GEN)
    |=> !s_axis_tready)
    else $error("command taken during a generate");

  // loads, clears and unused ops never raise a sample
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && (s_axis_tuser != wtm_pkg::OP_GEN)
    && !m_axis_tvalid |=> !m_axis_tvalid)
    else $error("sample without a generate");

endmodule

bind wavetable_tone_mixer_unit wtm_checker u_wtm_checker (.*);

`default_nettype wire

// File: test/tb.sv
// tb: self-checking testbench of wavetable_tone_mixer_unit
// drives command, sample and register-write streams and predicts each mixed sample
// depends on wtm_pkg and wavetable_tone_mixer_unit
`timescale 1ns / 100ps

module tb;
  import wtm_pkg::*;

  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int SESSION_ITEMS = 128;
  localparam int SETTLE_CYCLES = 40;
  // op value that the block ignores
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

  // predicted tables, phases and registers plus the expected samples
  class sample_scoreboard;
    logic signed [SAMPLE_W-1:0] wave_mem [NUM_WAVES_DEF][TABLE_DEPTH_DEF];
    bit loaded [NUM_WAVES_DEF][TABLE_DEPTH_DEF];
    int phase [NUM_CHANNELS_DEF];
    int tlen;
    int gain;
    int wsel;
    bit eight_bit;
    logic [SAMPLE_W-1:0] pending_samples [$];
    int errors;

    function new();
      tlen = 8000;
      gain = 10000;
      wsel = 0;
      eight_bit = 1'b0;
      errors = 0;
      foreach (phase[c]) phase[c] = 0;
    endfunction

    function int wave_of(int c);
      return ((wsel >> (2 * c)) & 3) % NUM_WAVES_DEF;
    endfunction

    function void note_config(cfg_reg_e idx, logic [CFG_DAT_W-1:0] data);
      case (idx)
        REG_TLEN: tlen = data[TLEN_W-1:0];
        REG_GAIN: gain = data[GAIN_W-1:0];
        REG_WSEL: wsel = data[WSEL_W-1:0];
        REG_EBIT: eight_bit = data[0];
        default: ;
      endcase
    endfunction

    function void note_command(logic [OP_W-1:0] op, logic [S_TDATA_W-1:0] data);
      int len;
      int sum;
      int x;
      int w;
      int p;
      int f;
      bit started;
      if (op == OP_LOAD) begin
        w = data[WID_LSB +: WID_W];
        p = data[ADDR_LSB +: ADDR_W];
        wave_mem[w][p] = data[VAL_LSB +: SAMPLE_W];
        loaded[w][p] = 1'b1;
      end else if (op == OP_CLEAR) begin
        foreach (phase[c]) phase[c] = 0;
      end else if (op == OP_GEN) begin
        len = (tlen == 0) ? 1 : (tlen > TABLE_DEPTH_DEF) ? TABLE_DEPTH_DEF : tlen;
        started = 1'b0;
        sum = 0;
        // enabled channels in order: read at the old phase, then step it
        for (int c = 0; c < FIELD_CHANNELS && c < NUM_CHANNELS_DEF; c++) begin
          if (data[EN_LSB + c]) begin
            w = wave_of(c);
            p = (phase[c] >= TABLE_DEPTH_DEF) ? 0 : phase[c];
            x = wave_mem[w][p];
            f = data[FREQ_LSB + c * FREQ_W +: FREQ_W];
            if (!started) begin
              // gain scaling truncates toward zero, then wraps to 16 bits
              sum = (x * gain) / GAIN_UNIT;
              sum = $signed(sum[SAMPLE_W-1:0]);
              started = 1'b1;
            end else begin
              sum = (sum + x) / 2;
            end
            phase[c] = (p + f) % len;
          end
        end
        if (eight_bit) sum = sum / (1 << BYTE_SHIFT) + BYTE_BIAS;
        pending_samples.push_back(sum[SAMPLE_W-1:0]);
      end
    endfunction

    function void check_sample(logic [SAMPLE_W-1:0] got);
      logic [SAMPLE_W-1:0] want;
      if (pending_samples.size() == 0) begin
        $error("sample_out: unexpected transaction, expected none, actual %0d",
               $signed(got));
        errors++;
      end else begin
        want = pending_samples.pop_front();
        if (got !== want) begin
          $error("sample_out: expected %0d, actual %0d", $signed(want), $signed(got));
          errors++;
        end
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni;
  logic s_axis_tvalid;
  logic s_axis_tready;
  logic [S_TDATA_W-1:0] s_axis_tdata;
  logic [OP_W-1:0] s_axis_tuser;
  logic m_axis_tvalid;
  logic m_axis_tready;
  logic [M_TDATA_W-1:0] m_axis_tdata;
  logic cfg_valid_i;
  logic cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i;
  logic [CFG_DAT_W-1:0] cfg_data_i;
  int send_gap_pct;
  int recv_stall_pct;
  int sent;
  sample_scoreboard sb;

  wavetable_tone_mixer_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  // sample side: check each transaction, stall at random
  always @(posedge clk_i) begin
    if (m_axis_tvalid && m_axis_tready) sb.check_sample(m_axis_tdata);
    m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // give up on a hung run
  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk_i);
    $display("Simulation FAILED");
    $finish;
  end

  // random command word with the byte padding cleared
  function automatic logic [S_TDATA_W-1:0] noise_word();
    logic [S_TDATA_W-1:0] w;
    w = S_TDATA_W'({$urandom, $urandom, $urandom, $urandom});
    w[S_TDATA_W-1:IN_BITS] = '0;
    return w;
  endfunction

  // valid stays high between back-to-back commands
  task automatic send_command(input logic [OP_W-1:0] op,
                              input logic [S_TDATA_W-1:0] data);
    while ($urandom_range(99) < send_gap_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= data;
    s_axis_tuser  <= op;
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_command(op, data);
    sent++;
  endtask

  task automatic load_word(input logic [WID_W-1:0] w, input logic [ADDR_W-1:0] a,
                           input logic [SAMPLE_W-1:0] v);
    logic [S_TDATA_W-1:0] d;
    d = noise_word();
    d[WID_LSB +: WID_W] = w;
    d[ADDR_LSB +: ADDR_W] = a;
    d[VAL_LSB +: SAMPLE_W] = v;
    send_command(OP_LOAD, d);
  endtask

  task automatic generate_sample(input logic [EN_W-1:0] en,
                                 input logic [FIELD_CHANNELS*FREQ_W-1:0] freqs);
    logic [S_TDATA_W-1:0] d;
    int w;
    int p;
    // a channel must never read a table word that was not loaded
    for (int c = 0; c < FIELD_CHANNELS; c++) begin
      if (en[c]) begin
        w = sb.wave_of(c);
        p = sb.phase[c];
        if (!sb.loaded[w][p]) load_word(WID_W'(w), ADDR_W'(p), SAMPLE_W'($urandom));
      end
    end
    d = noise_word();
    d[EN_LSB +: EN_W] = en;
    d[FREQ_LSB +: FIELD_CHANNELS*FREQ_W] = freqs;
    send_command(OP_GEN, d);
  endtask

  // stop sending until every expected sample is back
  task automatic wait_drained(input int settle);
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (sb.pending_samples.size() != 0);
    repeat (settle) @(posedge clk_i);
  endtask

  // consecutive writes keep valid high, the caller lowers it
  task automatic write_reg(input cfg_reg_e idx, input logic [CFG_DAT_W-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.note_config(idx, data);
  endtask

  // mostly generates with loads mixed in, some clears and ignored ops
  task automatic run_session(input int n_items);
    int first;
    int pick;
    bit paused;
    logic [EN_W-1:0] en;
    logic [FIELD_CHANNELS*FREQ_W-1:0] fq;
    logic [SAMPLE_W-1:0] v;
    first = sent;
    paused = 1'b0;
    while (sent - first < n_items) begin
      if (!paused && sent - first >= n_items / 2) begin
        wait_drained(0);
        paused = 1'b1;
      end
      pick = $urandom_range(99);
      if (pick < 55) begin
        en = EN_W'($urandom);
        for (int c = 0; c < FIELD_CHANNELS; c++) begin
          case ($urandom_range(4))
            1: fq[c*FREQ_W +: FREQ_W] = FREQ_W'($urandom_range(40));
            2: fq[c*FREQ_W +: FREQ_W] = '1;
            3: fq[c*FREQ_W +: FREQ_W] = '0;
            default: fq[c*FREQ_W +: FREQ_W] = FREQ_W'($urandom);
          endcase
        end
        generate_sample(en, fq);
      end else if (pick < 78) begin
        load_word(WID_W'($urandom),
                  $urandom_range(1) ? ADDR_W'($urandom_range(63)) : ADDR_W'($urandom),
                  SAMPLE_W'($urandom));
      end else if (pick < 85) begin
        case ($urandom_range(3))
          0: v = 16'h8000;
          1: v = 16'h7FFF;
          2: v = 16'h0000;
          default: v = 16'hFFFF;
        endcase
        load_word(WID_W'($urandom), ADDR_W'($urandom_range(63)), v);
      end else if (pick < 94) begin
        send_command(OP_CLEAR, noise_word());
      end else begin
        send_command(OP_UNUSED, noise_word());
      end
    end
  endtask

  initial begin
    int tl;
    int gn;
    logic [WSEL_W-1:0] ws;
    bit eb;
    sb = new();
    sent = 0;
    rst_ni = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = OP_LOAD;
    m_axis_tready = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_index_i = REG_TLEN;
    cfg_data_i = '0;
    send_gap_pct = 0;
    recv_stall_pct = 0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: extreme samples and addresses, every op, reset settings
    load_word(2'd0, 14'd0, 16'h7FFF);
    load_word(2'd1, 14'd0, 16'h8000);
    load_word(2'd2, 14'h3FFF, 16'h0000);
    load_word(2'd3, 14'h3FFF, 16'hFFFF);
    generate_sample(4'h0, '0);
    generate_sample(4'hF, '0);
    generate_sample(4'h1, {FIELD_CHANNELS{14'h3FFF}});
    send_command(OP_UNUSED, noise_word());
    generate_sample(4'hF, {FIELD_CHANNELS{14'h3FFF}});
    send_command(OP_CLEAR, noise_word());
    generate_sample(4'hA, {14'd1, 14'd2, 14'd3, 14'd4});
    load_word(2'd0, 14'd0, 16'h8000);
    send_command(OP_CLEAR, noise_word());
    generate_sample(4'h1, '0);

    // settings alternate long and short lengths so old phases exceed the new one
    for (int s = 0; s < 8; s++) begin
      case (s)
        0: begin tl = 16384; gn = 10000; ws = 8'hE4; eb = 1'b0; end
        1: begin tl = 1;     gn = 32767; ws = 8'hFF; eb = 1'b1; end
        2: begin tl = 32767; gn = 0;     ws = 8'h1B; eb = 1'b0; end
        3: begin tl = 0;     gn = 1;     ws = 8'h00; eb = 1'b1; end
        4: begin
          tl = 5000;
          gn = $urandom_range(32767);
          ws = WSEL_W'($urandom);
          eb = 1'b0;
        end
        default: begin
          tl = (s == 6) ? 16384 : $urandom_range(400, 2);
          gn = $urandom_range(32767);
          ws = WSEL_W'($urandom);
          eb = 1'($urandom_range(1));
        end
      endcase
      wait_drained(SETTLE_CYCLES);
      write_reg(REG_TLEN, CFG_DAT_W'(tl));
      write_reg(REG_GAIN, CFG_DAT_W'(gn));
      write_reg(REG_WSEL, {7'($urandom), ws});
      write_reg(REG_EBIT, {14'($urandom), eb});
      cfg_valid_i <= 1'b0;
      @(posedge clk_i);
      case (s % 4)
        0: begin send_gap_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_gap_pct = 62; recv_stall_pct = 0;  end
        2: begin send_gap_pct = 0;  recv_stall_pct = 62; end
        default: begin send_gap_pct = 26; recv_stall_pct = 26; end
      endcase
      run_session(SESSION_ITEMS);
    end

    wait_drained(SETTLE_CYCLES);
    if (sb.errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// File: filelist.f
src/wtm_pkg.sv
src/wtm_lane.sv
src/wtm_mixer.sv
src/wavetable_tone_mixer_unit.sv
src/wtm_checker.sv
test/tb.sv
